// File: sv/vertical_resample_mac_core_defines.svh
// ----------------------------------------------------------------------------
// vertical_resample_mac_core_defines
// assertion macros used by the checker file of the resample core
// ----------------------------------------------------------------------------
`ifndef VERTICAL_RESAMPLE_MAC_CORE_DEFINES_SVH
`define VERTICAL_RESAMPLE_MAC_CORE_DEFINES_SVH

// concurrent assertion, off while reset is asserted
`define VRM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that is checked during reset too
`define VRM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/vrm_pkg.sv
// ----------------------------------------------------------------------------
// vrm_pkg
// types and constants of the vertical resample multiply-accumulate core
// ----------------------------------------------------------------------------
package vrm_pkg;

  localparam int unsigned SampleWidth = 14;
  localparam int unsigned CoefWidth   = 16;
  localparam int unsigned TermWidth   = 16;
  localparam int unsigned AccWidth    = 16;
  localparam int unsigned OutWidth    = 14;
  localparam int unsigned PackedShift = 7;
  localparam int unsigned PackedBits  = 8;

  // 16383 less the rounding margin
  localparam logic [OutWidth-1:0] ClampHigh = OutWidth'(16383 - 42);

  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned OutDataWidth = 48;
  localparam int unsigned AddrWidth    = 3;

  // value of the top address bit that selects the input format register
  localparam logic RegInputFormat = 1'b0;

  typedef enum logic {
    FmtPlanar = 1'b0,
    FmtPacked = 1'b1
  } fmt_e;

  typedef struct packed {
    logic en;
    logic last;
  } acc_ctrl_t;

endpackage

// File: sv/vrm_term.sv
// ----------------------------------------------------------------------------
// vrm_term
// prescales one sample and forms the doubled high half of sample times weight
// ----------------------------------------------------------------------------
module vrm_term (
  input  vrm_pkg::fmt_e                        fmt_i,
  input  logic [vrm_pkg::SampleWidth-1:0]      sample_i,
  input  logic signed [vrm_pkg::CoefWidth-1:0] coef_i,
  output logic signed [vrm_pkg::TermWidth-1:0] term_o
);
  import vrm_pkg::*;

  logic [TermWidth-1:0]                scaled;
  logic signed [TermWidth+CoefWidth-1:0] prod;

  always_comb begin
    if (fmt_i == FmtPacked) begin
      scaled = {1'b0, sample_i[PackedBits-1:0], {PackedShift{1'b0}}};
    end else begin
      scaled = {1'b0, sample_i, 1'b0};
    end
  end

  // scaled never has its top bit set, so it is a valid signed operand
  assign prod = $signed(scaled) * coef_i;

  // arithmetic shift by 16, then doubled with 16-bit wrap
  assign term_o = $signed({prod[TermWidth+CoefWidth-2:CoefWidth], 1'b0});

endmodule

// File: sv/vrm_acc.sv
// ----------------------------------------------------------------------------
// vrm_acc
// one channel accumulator with signed saturation and output clamp
// ----------------------------------------------------------------------------
module vrm_acc (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  vrm_pkg::acc_ctrl_t                   ctrl_i,
  input  logic signed [vrm_pkg::TermWidth-1:0] term_i,
  output logic [vrm_pkg::OutWidth-1:0]         value_o
);
  import vrm_pkg::*;

  logic signed [AccWidth-1:0] acc_q, acc_d;
  logic signed [AccWidth:0]   sum;
  logic signed [AccWidth-1:0] sat;

  assign sum = {acc_q[AccWidth-1], acc_q} + {term_i[TermWidth-1], term_i};

  always_comb begin
    if (sum[AccWidth] != sum[AccWidth-1]) begin
      sat = sum[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    end else begin
      sat = sum[AccWidth-1:0];
    end
  end

  always_comb begin
    if (sat[AccWidth-1]) begin
      value_o = '0;
    end else if (sat > $signed({{(AccWidth-OutWidth){1'b0}}, ClampHigh})) begin
      value_o = ClampHigh;
    end else begin
      value_o = sat[OutWidth-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = ctrl_i.last ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// File: sv/vertical_resample_mac_core.sv
// ----------------------------------------------------------------------------
// vertical_resample_mac_core
// vertical resampling filter tap accumulator, blue, green and red in parallel
// ----------------------------------------------------------------------------
// Takes one filter tap per clock and gives one pixel after each tap marked
// tlast. A tap passes an input register, a 16x16 multiplier per channel with
// its term register, and the accumulators feeding the output register. Once
// its last tap has passed the input and term registers, a pixel shows on
// m_axis_tvalid. Every stage moves on its own: while a finished pixel waits
// for m_axis_tready, taps flow on until the next last tap is in the term
// register and the input register is full; only then does s_axis_tready
// drop. With a ready sink the sustained rate is one tap per cycle.
module vertical_resample_mac_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tap stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_blue[13:0], sample_green[27:14], sample_red[41:28], coefficient[57:42]
  input  logic [vrm_pkg::InDataWidth-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  // pixel stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_blue[13:0], out_green[27:14], out_red[41:28]
  output logic [vrm_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vrm_pkg::AddrWidth-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import vrm_pkg::*;

  localparam int unsigned NumCh = 3;

  fmt_e fmt_q;

  logic                          s1_valid_q;
  logic [SampleWidth-1:0]        s1_sample_q [NumCh];
  logic signed [CoefWidth-1:0]   s1_coef_q;
  logic                          s1_last_q;

  logic                          s2_valid_q;
  logic signed [TermWidth-1:0]   s2_term_q [NumCh];
  logic                          s2_last_q;

  logic                          out_valid_q;
  logic [OutWidth-1:0]           out_q [NumCh];

  logic signed [TermWidth-1:0]   term [NumCh];
  logic [OutWidth-1:0]           value [NumCh];
  acc_ctrl_t                     acc_ctrl;

  logic out_free, s2_go, s2_free, s1_go, s_accept, cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrWidth-1] == RegInputFormat);
  assign prdata = (paddr[AddrWidth-1] == RegInputFormat) ? {31'b0, fmt_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtPlanar;
    end else if (cfg_wr) begin
      fmt_q <= fmt_e'(pwdata[0]);
    end
  end

  // per-stage flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s2_go         = s2_valid_q && (!s2_last_q || out_free);
  assign s2_free       = !s2_valid_q || s2_go;
  assign s1_go         = s1_valid_q && s2_free;
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_go && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_sample_q[0] <= s_axis_tdata[SampleWidth-1:0];
      s1_sample_q[1] <= s_axis_tdata[2*SampleWidth-1:SampleWidth];
      s1_sample_q[2] <= s_axis_tdata[3*SampleWidth-1:2*SampleWidth];
      s1_coef_q      <= $signed(s_axis_tdata[3*SampleWidth+CoefWidth-1:3*SampleWidth]);
      s1_last_q      <= s_axis_tlast;
    end
    if (s1_go) begin
      s2_term_q <= term;
      s2_last_q <= s1_last_q;
    end
    if (s2_go && s2_last_q) begin
      out_q <= value;
    end
  end

  assign acc_ctrl.en   = s2_go;
  assign acc_ctrl.last = s2_last_q;

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    vrm_term u_term (
      .fmt_i    (fmt_q),
      .sample_i (s1_sample_q[c]),
      .coef_i   (s1_coef_q),
      .term_o   (term[c])
    );

    vrm_acc u_acc (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (acc_ctrl),
      .term_i  (s2_term_q[c]),
      .value_o (value[c])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-NumCh*OutWidth){1'b0}}, out_q[2], out_q[1], out_q[0]};

endmodule

// File: sv/vrm_checker.sv
// ----------------------------------------------------------------------------
// vrm_checker
// port-level checks of the resample core, bound to the top level
// ----------------------------------------------------------------------------
`include "vertical_resample_mac_core_defines.svh"

module vrm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [vrm_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [vrm_pkg::AddrWidth-1:0]    paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata
);
  import vrm_pkg::*;

  logic idle_in;

  assign idle_in = m_axis_tready && !(s_axis_tvalid && s_axis_tready);

  // a stalled pixel holds
  `VRM_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "pixel changed while stalled")

  // every channel stays inside the clamp range
  `VRM_ASSERT(a_out_range, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[13:0] <= ClampHigh) && (m_axis_tdata[27:14] <= ClampHigh)
      && (m_axis_tdata[41:28] <= ClampHigh), "pixel outside clamp range")

  // with no new taps and a ready sink the pipeline drains
  `VRM_ASSERT(a_drain, clk_i, rst_ni,
    idle_in ##1 idle_in ##1 idle_in |=> !m_axis_tvalid,
    "pipeline did not drain")

  // a format write reads back right after
  `VRM_ASSERT(a_fmt_readback, clk_i, rst_ni,
    psel && penable && pwrite && (paddr[AddrWidth-1] == RegInputFormat)
      |=> (paddr[AddrWidth-1] != RegInputFormat) || (prdata[0] == $past(pwdata[0])),
    "format register readback mismatch")

endmodule

bind vertical_resample_mac_core vrm_checker u_vrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
